// ===== hdl/pcw_pkg.sv =====
package pcw_pkg;

  // Fixed formats
  localparam int MAX_LENGTH = 4096;
  localparam int FRAC_BITS  = 16;
  localparam int IDX_W      = 12;
  localparam int LEN_W      = 13;
  localparam int COEF_W     = FRAC_BITS + 1;
  localparam int T_W        = FRAC_BITS + 2;   // t in Q2.F
  localparam int U_W        = FRAC_BITS + 1;   // folded t, at most 1.0
  localparam int A_W        = FRAC_BITS + 2;   // angle in Q2.F
  localparam int QW         = 30;              // series and root precision
  localparam int M_W        = 31;              // reciprocal multiplier width

  // Divider: two quotient bits per stage
  localparam int DIV_BITS   = 2;
  localparam int DIV_STAGES = T_W / DIV_BITS;

  // Square root: one root bit per stage
  localparam int SQRT_STAGES = QW + 1;

  // Gain 1.9979 in Q2.F, rounded to nearest
  localparam longint GAIN_INT = ((longint'(19979) << FRAC_BITS) + 64'd5000) / 64'd10000;
  localparam logic [A_W-1:0] GAIN_Q = A_W'(GAIN_INT);

  localparam logic [QW:0] QONE = (QW + 1)'(1) << QW;

  // Sine series divisors 110, 72, 42, 20, 6 as exact reciprocals for
  // dividends below 2^30: floor(y / c) == (y * M) >> S
  localparam int NUM_TERMS = 5;
  localparam logic [M_W-1:0] RECIP_M [NUM_TERMS] = '{
    31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
  };
  localparam int RECIP_S [NUM_TERMS] = '{37, 37, 36, 35, 33};

  // Per-stage control travelling with each word
  typedef struct packed {
    logic valid;
    logic oor;
    logic inv;
  } pcw_tag_t;

endpackage

// ===== hdl/power_complementary_window_generator.sv =====
// Channel  | Signals                                       | Direction
// ---------+-----------------------------------------------+----------
// config   | window_length_we_i, window_length_i           | in
// index    | in_valid_i, in_stall_o, sample_index_i        | in
// coeff    | out_valid_o, out_stall_i, coefficient_o,      | out
//          | index_out_of_range_o                          |
//
// One word per clock; the pipe holds 9 divider stages (two quotient
// bits each), 14 fold/series/power stages, 31 square-root stages (one root
// bit each) and the output register.
// The whole pipe advances on one enable, held off only while the output
// register is full and stalled. Reset empties the pipe and sets the
// length to 1024.
module power_complementary_window_generator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           window_length_we_i,
  input  logic [pcw_pkg::LEN_W-1:0]      window_length_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [pcw_pkg::IDX_W-1:0]      sample_index_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pcw_pkg::COEF_W-1:0]     coefficient_o,
  output logic                           index_out_of_range_o
);

  localparam int QW = pcw_pkg::QW;
  localparam logic [pcw_pkg::LEN_W-1:0] LEN_MAX = pcw_pkg::LEN_W'(pcw_pkg::MAX_LENGTH);
  localparam logic [QW+1:0] ROUND = (QW + 2)'(1) << (QW - 1 - pcw_pkg::FRAC_BITS);
  localparam logic [pcw_pkg::COEF_W:0] ONE_F = (pcw_pkg::COEF_W + 1)'(1) << pcw_pkg::FRAC_BITS;

  // Length register
  logic [pcw_pkg::LEN_W-1:0] wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q <= pcw_pkg::LEN_W'(1024);
    end else if (window_length_we_i) begin
      wl_q <= window_length_i;
    end
  end

  // Pipe enable
  logic ce;
  logic out_valid_q;

  assign ce         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !ce;

  // Range check on entry
  logic [pcw_pkg::LEN_W-1:0] n_eff;
  pcw_pkg::pcw_tag_t         in_tag;

  assign n_eff        = (wl_q > LEN_MAX) ? LEN_MAX : wl_q;
  assign in_tag.valid = in_valid_i;
  assign in_tag.oor   = (n_eff == '0) || (pcw_pkg::LEN_W'(sample_index_i) >= n_eff);
  assign in_tag.inv   = 1'b0;

  pcw_pkg::pcw_tag_t          div_tag;
  logic [pcw_pkg::T_W-1:0]    t;
  pcw_pkg::pcw_tag_t          sin_tag;
  logic [QW:0]                v;
  pcw_pkg::pcw_tag_t          sq_tag;
  logic [QW:0]                r;

  pcw_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .tag_i  (in_tag),
    .k_i    (sample_index_i),
    .n_i    (n_eff),
    .tag_o  (div_tag),
    .t_o    (t)
  );

  pcw_sin u_sin (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .tag_i  (div_tag),
    .t_i    (t),
    .tag_o  (sin_tag),
    .v_o    (v)
  );

  pcw_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ce_i   (ce),
    .tag_i  (sin_tag),
    .v_i    (v),
    .tag_o  (sq_tag),
    .r_o    (r)
  );

  // Round root to Q1.F and register the output word
  logic [QW+1:0]               rr;
  logic [pcw_pkg::COEF_W:0]    coef_full;
  logic [pcw_pkg::COEF_W-1:0]  coef_d;
  logic [pcw_pkg::COEF_W-1:0]  coef_q;
  logic                        oor_q;

  assign rr        = (QW + 2)'(r) + ROUND;
  assign coef_full = (pcw_pkg::COEF_W + 1)'(rr >> (QW - pcw_pkg::FRAC_BITS));

  always_comb begin
    if (sq_tag.oor) begin
      coef_d = '0;
    end else if (coef_full > ONE_F) begin
      coef_d = pcw_pkg::COEF_W'(ONE_F);
    end else begin
      coef_d = pcw_pkg::COEF_W'(coef_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ce) begin
      out_valid_q <= sq_tag.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      coef_q <= coef_d;
      oor_q  <= sq_tag.oor;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign coefficient_o        = coef_q;
  assign index_out_of_range_o = oor_q;

  // Checks
  a_oor_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && oor_q |-> coef_q == '0)
    else $error("out-of-range word carries a nonzero coefficient");

  a_coef_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> {1'b0, coef_q} <= ONE_F)
    else $error("coefficient above 1.0");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q && out_stall_i)
    else $error("input stalled while output can drain");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(sq_tag) && $stable(r))
    else $error("pipe moved while stalled");

endmodule

// ===== hdl/pcw_div.sv =====
module pcw_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          ce_i,
  input  pcw_pkg::pcw_tag_t             tag_i,
  input  logic [pcw_pkg::IDX_W-1:0]     k_i,
  input  logic [pcw_pkg::LEN_W-1:0]     n_i,
  output pcw_pkg::pcw_tag_t             tag_o,
  output logic [pcw_pkg::T_W-1:0]       t_o
);

  pcw_pkg::pcw_tag_t                tag_q  [pcw_pkg::DIV_STAGES];
  logic [pcw_pkg::LEN_W-1:0]        rem_q  [pcw_pkg::DIV_STAGES];
  logic [pcw_pkg::T_W-1:0]          quot_q [pcw_pkg::DIV_STAGES];

  // Restoring division of (k << (F+2)) by n, quotient bits MSB first
  for (genvar j = 0; j < pcw_pkg::DIV_STAGES; j++) begin : g_stage
    pcw_pkg::pcw_tag_t          tag_in;
    logic [pcw_pkg::LEN_W-1:0]  rem_in;
    logic [pcw_pkg::T_W-1:0]    quot_in;
    logic [pcw_pkg::LEN_W-1:0]  rem_d;
    logic [pcw_pkg::T_W-1:0]    quot_d;

    if (j == 0) begin : g_first
      assign tag_in  = tag_i;
      assign rem_in  = pcw_pkg::LEN_W'(k_i);
      assign quot_in = '0;
    end else begin : g_next
      assign tag_in  = tag_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign quot_in = quot_q[j-1];
    end

    always_comb begin : p_step
      logic [pcw_pkg::LEN_W-1:0] r2;
      rem_d  = rem_in;
      quot_d = quot_in;
      r2     = '0;
      for (int b = 0; b < pcw_pkg::DIV_BITS; b++) begin
        r2 = {rem_d[pcw_pkg::LEN_W-2:0], 1'b0};
        if (r2 >= n_i) begin
          rem_d  = r2 - n_i;
          quot_d = {quot_d[pcw_pkg::T_W-2:0], 1'b1};
        end else begin
          rem_d  = r2;
          quot_d = {quot_d[pcw_pkg::T_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j] <= '0;
      end else if (ce_i) begin
        tag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        rem_q[j]  <= rem_d;
        quot_q[j] <= quot_d;
      end
    end
  end

  assign tag_o = tag_q[pcw_pkg::DIV_STAGES-1];
  assign t_o   = quot_q[pcw_pkg::DIV_STAGES-1];

endmodule

// ===== hdl/pcw_sin.sv =====
module pcw_sin (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      ce_i,
  input  pcw_pkg::pcw_tag_t         tag_i,
  input  logic [pcw_pkg::T_W-1:0]   t_i,
  output pcw_pkg::pcw_tag_t         tag_o,
  output logic [pcw_pkg::QW:0]      v_o
);

  localparam int QW = pcw_pkg::QW;
  localparam logic [pcw_pkg::T_W:0] TWO_F  = (pcw_pkg::T_W + 1)'(2) << pcw_pkg::FRAC_BITS;
  localparam logic [pcw_pkg::T_W:0] FOUR_F = (pcw_pkg::T_W + 1)'(4) << pcw_pkg::FRAC_BITS;
  localparam int AU_W = pcw_pkg::U_W + pcw_pkg::A_W;
  localparam logic [AU_W-1:0] A_HALF = AU_W'(1) << (pcw_pkg::FRAC_BITS - 1);
  localparam int NT = pcw_pkg::NUM_TERMS;

  // ---- fold and gain ----
  pcw_pkg::pcw_tag_t            f_tag_q;
  logic [pcw_pkg::A_W-1:0]      a_q;
  pcw_pkg::pcw_tag_t            f_tag_d;
  logic [pcw_pkg::U_W-1:0]      u;
  logic [AU_W-1:0]              au;

  always_comb begin
    f_tag_d     = tag_i;
    f_tag_d.inv = (t_i[pcw_pkg::T_W-1 -: 2] == 2'd1) || (t_i[pcw_pkg::T_W-1 -: 2] == 2'd2);
    case (t_i[pcw_pkg::T_W-1 -: 2])
      2'd0:    u = pcw_pkg::U_W'({1'b0, t_i});
      2'd1:    u = pcw_pkg::U_W'(TWO_F - {1'b0, t_i});
      2'd2:    u = pcw_pkg::U_W'({1'b0, t_i} - TWO_F);
      default: u = pcw_pkg::U_W'(FOUR_F - {1'b0, t_i});
    endcase
    au = AU_W'(u) * AU_W'(pcw_pkg::GAIN_Q) + A_HALF;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_tag_q <= '0;
    end else if (ce_i) begin
      f_tag_q <= f_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      a_q <= pcw_pkg::A_W'(au >> pcw_pkg::FRAC_BITS);
    end
  end

  // ---- x = a/2 in Q0.30, x^2 ----
  pcw_pkg::pcw_tag_t  x_tag_q;
  logic [QW-1:0]      x_q;
  logic [QW-1:0]      x2_q;
  logic [QW-1:0]      x_d;
  logic [2*QW-1:0]    xx;

  assign x_d = QW'(a_q) << (QW - 1 - pcw_pkg::FRAC_BITS);
  assign xx  = (2*QW)'(x_d) * (2*QW)'(x_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_tag_q <= '0;
    end else if (ce_i) begin
      x_tag_q <= f_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      x_q  <= x_d;
      x2_q <= QW'(xx >> QW);
    end
  end

  // ---- Horner series: reciprocal stage per term, after a multiply stage for all but the first ----
  pcw_pkg::pcw_tag_t  d_tag_q [NT];
  logic [QW-1:0]      d_x_q   [NT];
  logic [QW-1:0]      d_x2_q  [NT];
  logic [QW-1:0]      d_q     [NT];
  pcw_pkg::pcw_tag_t  m_tag_q [1:NT-1];
  logic [QW-1:0]      m_x_q   [1:NT-1];
  logic [QW-1:0]      m_x2_q  [1:NT-1];
  logic [QW-1:0]      m_y_q   [1:NT-1];

  for (genvar i = 0; i < NT; i++) begin : g_term
    pcw_pkg::pcw_tag_t  src_tag;
    logic [QW-1:0]      src_x;
    logic [QW-1:0]      src_x2;
    logic [QW-1:0]      src_y;
    logic [QW+pcw_pkg::M_W-1:0] pm;

    if (i == 0) begin : g_first
      // first term divides x^2 directly
      assign src_tag = x_tag_q;
      assign src_x   = x_q;
      assign src_x2  = x2_q;
      assign src_y   = x2_q;
    end else begin : g_mul
      logic [QW:0]     p;
      logic [2*QW:0]   py;

      // y = x^2 * (1 - previous quotient)
      assign p  = pcw_pkg::QONE - {1'b0, d_q[i-1]};
      assign py = (2*QW + 1)'(d_x2_q[i-1]) * (2*QW + 1)'(p);

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          m_tag_q[i] <= '0;
        end else if (ce_i) begin
          m_tag_q[i] <= d_tag_q[i-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (ce_i) begin
          m_x_q[i]  <= d_x_q[i-1];
          m_x2_q[i] <= d_x2_q[i-1];
          m_y_q[i]  <= QW'(py >> QW);
        end
      end

      assign src_tag = m_tag_q[i];
      assign src_x   = m_x_q[i];
      assign src_x2  = m_x2_q[i];
      assign src_y   = m_y_q[i];
    end

    // floor(y / c) through the exact reciprocal
    assign pm = (QW + pcw_pkg::M_W)'(src_y) * (QW + pcw_pkg::M_W)'(pcw_pkg::RECIP_M[i]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        d_tag_q[i] <= '0;
      end else if (ce_i) begin
        d_tag_q[i] <= src_tag;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        d_x_q[i]  <= src_x;
        d_x2_q[i] <= src_x2;
        d_q[i]    <= QW'(pm >> pcw_pkg::RECIP_S[i]);
      end
    end
  end

  // ---- s = x * (1 - last quotient) ----
  pcw_pkg::pcw_tag_t  s_tag_q;
  logic [QW-1:0]      s_q;
  logic [QW:0]        sp;
  logic [2*QW:0]      sx;

  assign sp = pcw_pkg::QONE - {1'b0, d_q[NT-1]};
  assign sx = (2*QW + 1)'(d_x_q[NT-1]) * (2*QW + 1)'(sp);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tag_q <= '0;
    end else if (ce_i) begin
      s_tag_q <= d_tag_q[NT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      s_q <= QW'(sx >> QW);
    end
  end

  // ---- h = s^2 ----
  pcw_pkg::pcw_tag_t  h_tag_q;
  logic [QW-1:0]      h_q;
  logic [2*QW-1:0]    ss;

  assign ss = (2*QW)'(s_q) * (2*QW)'(s_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_tag_q <= '0;
    end else if (ce_i) begin
      h_tag_q <= s_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      h_q <= QW'(ss >> QW);
    end
  end

  // ---- v = h^2, complemented in the middle quarters ----
  pcw_pkg::pcw_tag_t  v_tag_q;
  logic [QW:0]        v_q;
  logic [2*QW-1:0]    hh;
  logic [QW:0]        vv;

  assign hh = (2*QW)'(h_q) * (2*QW)'(h_q);
  assign vv = {1'b0, QW'(hh >> QW)};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_tag_q <= '0;
    end else if (ce_i) begin
      v_tag_q <= h_tag_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      v_q <= h_tag_q.inv ? (pcw_pkg::QONE - vv) : vv;
    end
  end

  assign tag_o = v_tag_q;
  assign v_o   = v_q;

endmodule

// ===== hdl/pcw_sqrt.sv =====
module pcw_sqrt (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   ce_i,
  input  pcw_pkg::pcw_tag_t      tag_i,
  input  logic [pcw_pkg::QW:0]   v_i,
  output pcw_pkg::pcw_tag_t      tag_o,
  output logic [pcw_pkg::QW:0]   r_o
);

  localparam int NS    = pcw_pkg::SQRT_STAGES;
  localparam int QW    = pcw_pkg::QW;
  localparam int REM_W = QW + 2;
  localparam int N_W   = 2 * NS;

  pcw_pkg::pcw_tag_t  tag_q  [NS];
  logic [QW:0]        v_q    [NS];
  logic [REM_W-1:0]   rem_q  [NS];
  logic [QW:0]        root_q [NS];

  // Digit-by-digit square root of v << 30, one root bit per stage
  for (genvar j = 0; j < NS; j++) begin : g_stage
    pcw_pkg::pcw_tag_t  tag_in;
    logic [QW:0]        v_in;
    logic [REM_W-1:0]   rem_in;
    logic [QW:0]        root_in;
    logic [N_W-1:0]     radicand;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W-1:0]   rem_d;
    logic [QW:0]        root_d;

    if (j == 0) begin : g_first
      assign tag_in  = tag_i;
      assign v_in    = v_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign tag_in  = tag_q[j-1];
      assign v_in    = v_q[j-1];
      assign rem_in  = rem_q[j-1];
      assign root_in = root_q[j-1];
    end

    assign radicand = {1'b0, v_in, QW'(0)};
    assign rem_sh   = {rem_in, radicand[N_W-1-2*j -: 2]};
    assign trial    = {1'b0, root_in, 2'b01};

    always_comb begin
      if (rem_sh >= trial) begin
        rem_d  = REM_W'(rem_sh - trial);
        root_d = {root_in[QW-1:0], 1'b1};
      end else begin
        rem_d  = REM_W'(rem_sh);
        root_d = {root_in[QW-1:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[j] <= '0;
      end else if (ce_i) begin
        tag_q[j] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (ce_i) begin
        v_q[j]    <= v_in;
        rem_q[j]  <= rem_d;
        root_q[j] <= root_d;
      end
    end
  end

  assign tag_o = tag_q[NS-1];
  assign r_o   = root_q[NS-1];

endmodule

// ===== tb/power_complementary_window_generator_tb.sv =====
`timescale 1ns / 100ps

module power_complementary_window_generator_tb;

  localparam int LATENCY     = 55;
  localparam int LIMIT_CYCLE = 400000;
  localparam longint QONE_L  = 64'd1 << 30;
  localparam longint WIN_GAIN =
    ((64'd19979 << pcw_pkg::FRAC_BITS) + 64'd5000) / 64'd10000;

  typedef struct {
    logic [pcw_pkg::COEF_W-1:0] coef;
    logic                       oor;
  } coef_word_t;

  // Predicts window coefficients and checks them in order
  class window_scoreboard;
    coef_word_t   pending[$];
    logic [pcw_pkg::LEN_W-1:0] length_reg;
    int mismatches;

    function new();
      length_reg = pcw_pkg::LEN_W'(1024);
      mismatches = 0;
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
        if (n >= res + bitv) begin
          n -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Horner sine series in Q0.30
    function longint unsigned sine_q30(longint unsigned x);
      longint unsigned x2, p;
      x2 = (x * x) >> 30;
      p = QONE_L - x2 / 110;
      p = QONE_L - ((x2 * p) >> 30) / 72;
      p = QONE_L - ((x2 * p) >> 30) / 42;
      p = QONE_L - ((x2 * p) >> 30) / 20;
      p = QONE_L - ((x2 * p) >> 30) / 6;
      return (x * p) >> 30;
    endfunction

    function void note_index(logic [pcw_pkg::IDX_W-1:0] k);
      coef_word_t w;
      longint unsigned n, t, u, a, x, s, h, v, r, c, one_f;
      int q;
      n = length_reg;
      one_f = 64'd1 << pcw_pkg::FRAC_BITS;
      if (n > pcw_pkg::MAX_LENGTH) n = pcw_pkg::MAX_LENGTH;
      if (n == 0 || k >= n) begin
        w.coef = '0;
        w.oor  = 1'b1;
      end else begin
        t = ((longint'(k) << 2) << pcw_pkg::FRAC_BITS) / n;
        q = int'((t >> pcw_pkg::FRAC_BITS) & 3);
        case (q)
          0: u = t;
          1: u = 2 * one_f - t;
          2: u = t - 2 * one_f;
          default: u = 4 * one_f - t;
        endcase
        a = (u * WIN_GAIN + (one_f >> 1)) >> pcw_pkg::FRAC_BITS;
        x = a << (29 - pcw_pkg::FRAC_BITS);
        if (x >= QONE_L) x = QONE_L - 1;
        s = sine_q30(x);
        h = (s * s) >> 30;
        v = (h * h) >> 30;
        if (v > QONE_L) v = QONE_L;
        if (q == 1 || q == 2) v = QONE_L - v;
        r = int_sqrt(v << 30);
        c = (r + (64'd1 << (29 - pcw_pkg::FRAC_BITS))) >> (30 - pcw_pkg::FRAC_BITS);
        if (c > one_f) c = one_f;
        w.coef = pcw_pkg::COEF_W'(c);
        w.oor  = 1'b0;
      end
      pending.push_back(w);
    endfunction

    function void check_word(logic [pcw_pkg::COEF_W-1:0] coef, logic oor);
      coef_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: coef %0d oor %0d", coef, oor);
        return;
      end
      e = pending.pop_front();
      if (e.coef !== coef || e.oor !== oor) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected coef %0d oor %0d, got coef %0d oor %0d",
                   e.coef, e.oor, coef, oor);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic window_length_we_i = 1'b0;
  logic [pcw_pkg::LEN_W-1:0] window_length_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [pcw_pkg::IDX_W-1:0] sample_index_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [pcw_pkg::COEF_W-1:0] coefficient_o;
  logic index_out_of_range_o;

  window_scoreboard sb = new();
  int  cycle_count = 0;
  bit  hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  power_complementary_window_generator DUT (
    .clk_i, .rst_ni, .window_length_we_i, .window_length_i,
    .in_valid_i, .in_stall_o, .sample_index_i,
    .out_valid_o, .out_stall_i, .coefficient_o, .index_out_of_range_o
  );

  // Timeout watch
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLE) begin
      $display("power_complementary_window_generator_tb failed");
      $finish;
    end
  end

  // Output side: sample accepted words and pick next stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_word(coefficient_o, index_out_of_range_o);
      if (hold_off) out_stall_i <= 1'b1;
      else if (cycle_count % 700 < 200) out_stall_i <= 1'b0;
      else out_stall_i <= ($urandom_range(0, 3) == 0);
    end
  end

  // Long receiver hold-off while the sender keeps offering
  initial begin
    wait (cycle_count == 40);
    hold_off = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Offer one word, hold it until accepted
  task automatic send_index(logic [pcw_pkg::IDX_W-1:0] k);
    in_valid_i <= 1'b1;
    sample_index_i <= k;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_index(k);
  endtask

  task automatic idle_cycles(int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Write the length once the pipe has drained
  task automatic set_length(logic [pcw_pkg::LEN_W-1:0] len);
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    window_length_we_i <= 1'b1;
    window_length_i <= len;
    @(posedge clk_i);
    window_length_we_i <= 1'b0;
    sb.length_reg = len;
  endtask

  task automatic random_burst(int count, int len_hint);
    int sent, burst;
    sent = 0;
    while (sent < count) begin
      burst = $urandom_range(1, 12);
      for (int i = 0; i < burst && sent < count; i++) begin
        if ($urandom_range(0, 9) == 0) send_index(pcw_pkg::IDX_W'($urandom));
        else send_index(pcw_pkg::IDX_W'($urandom_range(0, (len_hint > 1 ? len_hint : 1) - 1)));
        sent++;
      end
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 5));
    end
  endtask

  initial begin
    int lens[8];
    lens = '{1, 4096, 8191, 0, 4, 1000, 4095, 1024};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset length, quarter edges, extremes
    send_index(12'd0);
    send_index(12'd256);
    send_index(12'd512);
    send_index(12'd768);
    send_index(12'd1023);
    send_index(12'd1024);
    send_index(12'd4095);
    send_index(12'hAAA);
    send_index(12'h555);
    random_burst(120, 1024);

    foreach (lens[i]) begin
      set_length(pcw_pkg::LEN_W'(lens[i]));
      send_index(12'd0);
      send_index(pcw_pkg::IDX_W'(lens[i] > 0 ? (lens[i] - 1) % 4096 : 0));
      send_index(12'd4095);
      random_burst(60, lens[i] > 4096 ? 4096 : lens[i]);
    end
    set_length(pcw_pkg::LEN_W'($urandom_range(1, 8191)));
    random_burst(40, 4096);
    in_valid_i <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("power_complementary_window_generator_tb passed");
    else
      $display("power_complementary_window_generator_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/pcw_pkg.sv
hdl/pcw_div.sv
hdl/pcw_sin.sv
hdl/pcw_sqrt.sv
hdl/power_complementary_window_generator.sv
tb/power_complementary_window_generator_tb.sv
